// ===== hdl/wtq_pkg.sv =====
// ----------------------------------------------------------------------------
// wtq_pkg: shared types and codes of the weighted two-class time queue
// Word layouts, operation and status codes, and the cell control bundle.
// ----------------------------------------------------------------------------
package wtq_pkg;

    localparam int MinuteW = 11;
    localparam int QuotaW  = 4;

    // operation codes
    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_SERVE  = 1'b1;

    // status codes
    localparam logic [1:0] STATUS_DONE  = 2'd0;
    localparam logic [1:0] STATUS_FULL  = 2'd1;
    localparam logic [1:0] STATUS_EMPTY = 2'd2;

    // reset value of the quota register
    localparam logic [QuotaW-1:0] QUOTA_RESET = 4'd3;

    // request word
    typedef struct packed {
        logic               operation;
        logic               client_class;
        logic               priority_flag;
        logic [MinuteW-1:0] arrival_minute;
    } wtq_req_t;

    // response word
    typedef struct packed {
        logic [1:0]         status;
        logic               served_class;
        logic               served_priority;
        logic [MinuteW-1:0] served_minute;
        logic [4:0]         occupancy;
    } wtq_rsp_t;

    // one queued entry
    typedef struct packed {
        logic               cls;
        logic               prio;
        logic [MinuteW-1:0] minute;
    } wtq_entry_t;

    // control broadcast to every cell
    typedef struct packed {
        logic       ins;        // insert new_entry in time order
        logic       rem;        // remove oldest entry whose prio equals want
        logic       want;
        wtq_entry_t new_entry;
    } wtq_ctl_t;

endpackage

// ===== hdl/wtq_cell.sv =====
// ----------------------------------------------------------------------------
// wtq_cell: one slot of the ordered queue
// Holds one entry; on insert it keeps, takes the new entry or takes its left
// neighbour; on removal it takes its right neighbour from the served slot on.
// ----------------------------------------------------------------------------
module wtq_cell (
    input  logic              clk,
    input  wtq_pkg::wtq_ctl_t ctl,
    input  logic              valid,
    input  wtq_pkg::wtq_entry_t left_entry,
    input  logic              left_le,
    input  wtq_pkg::wtq_entry_t right_entry,
    input  logic              found_in,
    input  wtq_pkg::wtq_entry_t served_in,
    output wtq_pkg::wtq_entry_t entry,
    output logic              le,
    output logic              found_out,
    output wtq_pkg::wtq_entry_t served_out
);

    wtq_pkg::wtq_entry_t entry_reg;
    wtq_pkg::wtq_entry_t entry_next;
    logic                match;
    logic                hit;

    // ordering flag: this entry is not newer than the incoming one
    assign le = valid && (entry_reg.minute <= ctl.new_entry.minute);

    // search chain for the oldest entry of the wanted kind
    assign match      = valid && (entry_reg.prio == ctl.want);
    assign hit        = match && !found_in;
    assign found_out  = found_in || match;
    assign served_out = hit ? entry_reg : served_in;

    // slot update
    always_comb
    begin
        entry_next = entry_reg;
        if (ctl.ins)
        begin
            if (!le)
            begin
                entry_next = left_le ? ctl.new_entry : left_entry;
            end
        end
        else if (ctl.rem)
        begin
            if (found_out)
            begin
                entry_next = right_entry;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    assign entry = entry_reg;

endmodule

// ===== hdl/weighted_two_class_time_queue_unit.sv =====
// ----------------------------------------------------------------------------
// weighted_two_class_time_queue_unit: time-ordered queue with priority quota
// Row of cells holding entries oldest first; inserts and weighted serves.
// ----------------------------------------------------------------------------
// A word accepted in the idle state is worked in the execute state, where the
// search and shift ripple through the row of cells and its response is
// registered; that state waits while an older response is still unread.
// One word is in work at a time, so the next word is taken only once this
// response is registered, even while it still waits to be read.
// Reset (rst_n, asynchronous, active low) empties the queue, clears the quota
// counter and loads the quota with three; slot contents are not cleared.
module weighted_two_class_time_queue_unit #(
    parameter int QUEUE_DEPTH = 16
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   req_valid,
    output logic                   req_ready,
    input  wtq_pkg::wtq_req_t      req,
    output logic                   rsp_valid,
    input  logic                   rsp_ready,
    output wtq_pkg::wtq_rsp_t      rsp,
    input  logic                   cfg_we,
    input  logic [wtq_pkg::QuotaW-1:0] cfg_data
);

    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam int QW = wtq_pkg::QuotaW;

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_EXEC = 2'b10
    } state_t;

    state_t              state_reg, state_next;
    wtq_pkg::wtq_req_t   req_reg;
    logic [CW-1:0]       count_reg, count_next;
    logic [CW-1:0]       prio_cnt_reg, prio_cnt_next;
    logic [QW-1:0]       quota_cnt_reg, quota_cnt_next;
    logic [QW-1:0]       quota_reg;
    wtq_pkg::wtq_rsp_t   rsp_reg, rsp_next;
    logic                rsp_valid_reg, rsp_valid_next;

    logic                fire, is_ins, full, empty, has_p, has_np;
    logic                want;
    wtq_pkg::wtq_ctl_t   ctl;
    logic [CW+4:0]       occ_ext;

    wtq_pkg::wtq_entry_t cell_entry [QUEUE_DEPTH];
    logic                cell_le    [QUEUE_DEPTH];
    logic                found      [QUEUE_DEPTH+1];
    wtq_pkg::wtq_entry_t served     [QUEUE_DEPTH+1];

    // request side handshake
    assign req_ready = (state_reg == ST_IDLE);
    assign fire      = (state_reg == ST_EXEC) && (!rsp_valid_reg || rsp_ready);

    // queue status
    assign is_ins = (req_reg.operation == wtq_pkg::OP_INSERT);
    assign full   = (count_reg == CW'(QUEUE_DEPTH));
    assign empty  = (count_reg == '0);
    assign has_p  = (prio_cnt_reg != '0);
    assign has_np = (prio_cnt_reg != count_reg);

    // serve selection and quota counter
    always_comb
    begin
        if (quota_cnt_reg < quota_reg)
        begin
            if (has_p)
            begin
                want           = 1'b1;
                quota_cnt_next = quota_cnt_reg + QW'(1);
            end
            else
            begin
                want           = 1'b0;
                quota_cnt_next = '0;
            end
        end
        else if (has_np)
        begin
            want           = 1'b0;
            quota_cnt_next = '0;
        end
        else
        begin
            want           = 1'b1;
            quota_cnt_next = (quota_reg != '0) ? quota_reg - QW'(1) : '0;
        end
    end

    // cell control broadcast
    always_comb
    begin
        ctl.ins              = fire && is_ins && !full;
        ctl.rem              = fire && !is_ins && !empty;
        ctl.want             = want;
        ctl.new_entry.cls    = req_reg.client_class;
        ctl.new_entry.prio   = req_reg.priority_flag;
        ctl.new_entry.minute = req_reg.arrival_minute;
    end

    // row of cells
    assign found[0]  = 1'b0;
    assign served[0] = '0;

    for (genvar i = 0; i < QUEUE_DEPTH; i++)
    begin : g_cell
        wtq_pkg::wtq_entry_t left_e, right_e;
        logic                left_l;
        logic                valid;

        assign valid = (count_reg > CW'(i));

        if (i == 0)
        begin : g_first
            assign left_e = ctl.new_entry;
            assign left_l = 1'b1;
        end
        else
        begin : g_mid
            assign left_e = cell_entry[i-1];
            assign left_l = cell_le[i-1];
        end

        if (i == QUEUE_DEPTH - 1)
        begin : g_last
            assign right_e = cell_entry[i];
        end
        else
        begin : g_inner
            assign right_e = cell_entry[i+1];
        end

        wtq_cell u_cell (
            .clk         (clk),
            .ctl         (ctl),
            .valid       (valid),
            .left_entry  (left_e),
            .left_le     (left_l),
            .right_entry (right_e),
            .found_in    (found[i]),
            .served_in   (served[i]),
            .entry       (cell_entry[i]),
            .le          (cell_le[i]),
            .found_out   (found[i+1]),
            .served_out  (served[i+1])
        );
    end

    // counts and response word
    always_comb
    begin
        count_next     = count_reg;
        prio_cnt_next  = prio_cnt_reg;
        rsp_next       = rsp_reg;
        rsp_valid_next = rsp_valid_reg;
        state_next     = state_reg;

        if (rsp_valid_reg && rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end

        if (ctl.ins)
        begin
            count_next = count_reg + CW'(1);
            if (req_reg.priority_flag)
            begin
                prio_cnt_next = prio_cnt_reg + CW'(1);
            end
        end
        else if (ctl.rem)
        begin
            count_next = count_reg - CW'(1);
            if (want)
            begin
                prio_cnt_next = prio_cnt_reg - CW'(1);
            end
        end

        occ_ext = {5'd0, count_next};

        unique case (state_reg)
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                if (fire)
                begin
                    state_next     = ST_IDLE;
                    rsp_valid_next = 1'b1;
                    rsp_next       = '0;
                    if (is_ins)
                    begin
                        rsp_next.status = full ? wtq_pkg::STATUS_FULL
                                               : wtq_pkg::STATUS_DONE;
                    end
                    else if (empty)
                    begin
                        rsp_next.status = wtq_pkg::STATUS_EMPTY;
                    end
                    else
                    begin
                        rsp_next.status          = wtq_pkg::STATUS_DONE;
                        rsp_next.served_class    = served[QUEUE_DEPTH].cls;
                        rsp_next.served_priority = served[QUEUE_DEPTH].prio;
                        rsp_next.served_minute   = served[QUEUE_DEPTH].minute;
                    end
                    rsp_next.occupancy = occ_ext[4:0];
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            prio_cnt_reg  <= '0;
            quota_cnt_reg <= '0;
            quota_reg     <= wtq_pkg::QUOTA_RESET;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            prio_cnt_reg  <= prio_cnt_next;
            rsp_valid_reg <= rsp_valid_next;
            if (ctl.rem)
            begin
                quota_cnt_reg <= quota_cnt_next;
            end
            if (cfg_we)
            begin
                quota_reg <= cfg_data;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        rsp_reg <= rsp_next;
        if (req_valid && req_ready)
        begin
            req_reg <= req;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

// ===== hdl/wtq_checker.sv =====
// ----------------------------------------------------------------------------
// wtq_port_checks: port-level checks of the time queue
// Watches the request, response and configuration ports over time.
// ----------------------------------------------------------------------------
module wtq_port_checks #(
    parameter int QUEUE_DEPTH = 16
) (
    input logic                   clk,
    input logic                   rst_n,
    input logic                   req_valid,
    input logic                   req_ready,
    input wtq_pkg::wtq_req_t      req,
    input logic                   rsp_valid,
    input logic                   rsp_ready,
    input wtq_pkg::wtq_rsp_t      rsp,
    input logic                   cfg_we,
    input logic [wtq_pkg::QuotaW-1:0] cfg_data
);

    localparam logic [4:0] FULL_OCC = 5'(QUEUE_DEPTH);

    // a waiting response word holds
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
        else $error("response word dropped or changed while stalled");

    // one word in work at a time
    a_one_in_work: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
        else $error("request taken while previous word in work");

    // status is never the unused code
    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> (rsp.status == wtq_pkg::STATUS_DONE ||
                       rsp.status == wtq_pkg::STATUS_FULL ||
                       rsp.status == wtq_pkg::STATUS_EMPTY))
        else $error("undefined status code");

    // a failed word serves nothing; full means the queue is at depth
    a_fail_empty: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.status == wtq_pkg::STATUS_FULL
            |-> rsp.occupancy == FULL_OCC && rsp.served_minute == '0)
        else $error("full response with wrong occupancy or served data");

    a_empty_occ: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.status == wtq_pkg::STATUS_EMPTY
            |-> rsp.occupancy == '0 && !rsp.served_priority && !rsp.served_class)
        else $error("empty response with entries or served data");

endmodule

bind weighted_two_class_time_queue_unit wtq_port_checks #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
) u_wtq_port_checks (.*);

// ===== test/wtq_checker.sv =====
// ----------------------------------------------------------------------------
// wtq_checker: response checker for the weighted two-class time queue
// Watches the request, response and quota ports and keeps its own copy of the
// queue. Every accepted request word is turned into the response it should
// get, and every accepted response word is compared field by field with the
// oldest response still outstanding.
// ----------------------------------------------------------------------------
module wtq_checker
    import wtq_pkg::*;
#(
    parameter int QUEUE_DEPTH = 16
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    input  logic              req_ready,
    input  wtq_req_t          req,
    input  logic              rsp_valid,
    input  logic              rsp_ready,
    input  wtq_rsp_t          rsp,
    input  logic              cfg_we,
    input  logic [QuotaW-1:0] cfg_data,
    output int                mismatches,
    output int                outstanding
);

    // shadow copy of the queue, oldest entry first
    wtq_entry_t        slot [QUEUE_DEPTH];
    int                held;
    logic [QuotaW-1:0] served_run;
    logic [QuotaW-1:0] quota;

    // responses still owed by the block, oldest first
    wtq_rsp_t          owed_rsp [$];

    // first slot whose priority bit equals want, or held when there is none
    function automatic int oldest_of(input logic want);
        int pos;
        pos = held;
        for (int i = held - 1; i >= 0; i--)
            if (slot[i].prio == want)
                pos = i;
        return pos;
    endfunction

    // remove one slot and close the gap behind it
    function automatic wtq_entry_t take_slot(input int pos);
        wtq_entry_t e;
        e = slot[pos];
        for (int i = pos; i + 1 < held; i++)
            slot[i] = slot[i + 1];
        held--;
        return e;
    endfunction

    // apply one request word to the shadow queue, return its response
    function automatic wtq_rsp_t queue_step(input wtq_req_t w);
        wtq_rsp_t   r;
        wtq_entry_t taken;
        int         pos;
        bit         done;
        r     = '0;
        taken = '0;
        done  = 1'b0;
        if (w.operation == OP_INSERT) begin
            if (held >= QUEUE_DEPTH) begin
                r.status = STATUS_FULL;
            end
            else begin
                // slide newer entries up; equal minutes stay first in, first out
                pos = held;
                while (pos > 0 && slot[pos - 1].minute > w.arrival_minute) begin
                    slot[pos] = slot[pos - 1];
                    pos--;
                end
                slot[pos].cls    = w.client_class;
                slot[pos].prio   = w.priority_flag;
                slot[pos].minute = w.arrival_minute;
                held++;
            end
        end
        else if (held == 0) begin
            r.status = STATUS_EMPTY;
        end
        else begin
            // quota still open: oldest priority entry
            if (served_run < quota) begin
                pos = oldest_of(1'b1);
                if (pos < held) begin
                    taken      = take_slot(pos);
                    served_run = served_run + 1'b1;
                    done       = 1'b1;
                end
                else begin
                    served_run = quota;
                end
            end
            // quota used: oldest non-priority entry, else back to priority
            if (!done) begin
                pos = oldest_of(1'b0);
                if (pos < held) begin
                    taken      = take_slot(pos);
                    served_run = '0;
                end
                else begin
                    pos = oldest_of(1'b1);
                    if (pos >= held)
                        pos = 0;
                    taken      = take_slot(pos);
                    served_run = (quota != '0) ? quota - 1'b1 : '0;
                end
            end
        end
        r.served_class    = taken.cls;
        r.served_priority = taken.prio;
        r.served_minute   = taken.minute;
        r.occupancy       = held[4:0];
        return r;
    endfunction

    // watch all three ports at each rising edge
    always @(posedge clk or negedge rst_n)
    begin
        wtq_rsp_t want;
        if (!rst_n) begin
            held        = 0;
            served_run  = '0;
            quota       = QUOTA_RESET;
            mismatches  = 0;
            owed_rsp.delete();
            outstanding = 0;
        end
        else begin
            if (cfg_we)
                quota = cfg_data;

            // response word: compare with the oldest one owed
            if (rsp_valid && rsp_ready) begin
                if (owed_rsp.size() == 0) begin
                    $error("response word with none outstanding: %h", rsp);
                    mismatches++;
                end
                else begin
                    want = owed_rsp.pop_front();
                    if (rsp.status !== want.status) begin
                        $error("status: expected %0d, got %0d", want.status, rsp.status);
                        mismatches++;
                    end
                    if (rsp.served_class !== want.served_class) begin
                        $error("served_class: expected %0d, got %0d",
                               want.served_class, rsp.served_class);
                        mismatches++;
                    end
                    if (rsp.served_priority !== want.served_priority) begin
                        $error("served_priority: expected %0d, got %0d",
                               want.served_priority, rsp.served_priority);
                        mismatches++;
                    end
                    if (rsp.served_minute !== want.served_minute) begin
                        $error("served_minute: expected %0d, got %0d",
                               want.served_minute, rsp.served_minute);
                        mismatches++;
                    end
                    if (rsp.occupancy !== want.occupancy) begin
                        $error("occupancy: expected %0d, got %0d",
                               want.occupancy, rsp.occupancy);
                        mismatches++;
                    end
                end
            end

            // request word: predict its response
            if (req_valid && req_ready)
                owed_rsp.push_back(queue_step(req));

            outstanding = owed_rsp.size();
        end
    end

endmodule

// ===== test/tb.sv =====
// ----------------------------------------------------------------------------
// tb: stimulus and verdict for the weighted two-class time queue
// Drives a directed opening (empty serve, extreme and repeated minutes, a
// full queue, quota-driven serves), then random phases of inserts and serves
// under several quota settings and idling mixes. A checker beside the block
// predicts and compares every response word.
// ----------------------------------------------------------------------------
module tb;

    localparam int Depth       = 16;
    localparam int PhaseWords  = 125;

    logic                       clk;
    logic                       rst_n;
    logic                       req_valid;
    logic                       req_ready;
    wtq_pkg::wtq_req_t          req;
    logic                       rsp_valid;
    logic                       rsp_ready;
    wtq_pkg::wtq_rsp_t          rsp;
    logic                       cfg_we;
    logic [wtq_pkg::QuotaW-1:0] cfg_data;

    int                mismatches;
    int                outstanding;

    // idling odds in percent
    int                send_idle;
    int                recv_idle;

    weighted_two_class_time_queue_unit #(
        .QUEUE_DEPTH (Depth)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp),
        .cfg_we    (cfg_we),
        .cfg_data  (cfg_data)
    );

    wtq_checker #(
        .QUEUE_DEPTH (Depth)
    ) queue_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .req_valid   (req_valid),
        .req_ready   (req_ready),
        .req         (req),
        .rsp_valid   (rsp_valid),
        .rsp_ready   (rsp_ready),
        .rsp         (rsp),
        .cfg_we      (cfg_we),
        .cfg_data    (cfg_data),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    // clock
    always #5 clk = ~clk;

    // receiver stalls at random
    always @(negedge clk)
    begin
        rsp_ready <= ($urandom_range(0, 99) >= recv_idle);
    end

    // hand one request word over, idling first at random
    task automatic send_word(input wtq_pkg::wtq_req_t w);
        @(negedge clk);
        while ($urandom_range(0, 99) < send_idle)
        begin
            req_valid <= 1'b0;
            @(negedge clk);
        end
        req_valid <= 1'b1;
        req       <= w;
        @(posedge clk);
        while (!req_ready)
            @(posedge clk);
    endtask

    function automatic wtq_pkg::wtq_req_t insert_word(
        input logic cls, input logic prio,
        input logic [wtq_pkg::MinuteW-1:0] minute);
        wtq_pkg::wtq_req_t w;
        w.operation      = wtq_pkg::OP_INSERT;
        w.client_class   = cls;
        w.priority_flag  = prio;
        w.arrival_minute = minute;
        return w;
    endfunction

    function automatic wtq_pkg::wtq_req_t serve_word();
        wtq_pkg::wtq_req_t w;
        w.operation      = wtq_pkg::OP_SERVE;
        w.client_class   = 1'($urandom_range(0, 1));
        w.priority_flag  = 1'($urandom_range(0, 1));
        w.arrival_minute = wtq_pkg::MinuteW'($urandom_range(0, 2047));
        return w;
    endfunction

    // let the block drain, then load a new quota
    task automatic load_quota(input logic [wtq_pkg::QuotaW-1:0] value);
        @(negedge clk);
        req_valid <= 1'b0;
        while (outstanding != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
        cfg_we   <= 1'b1;
        cfg_data <= value;
        @(negedge clk);
        cfg_we   <= 1'b0;
    endtask

    // random inserts and serves; odds shift every 25 words so the
    // queue swings between full and empty and one kind is often missing
    task automatic random_traffic(input int n_words);
        wtq_pkg::wtq_req_t w;
        int       fill_pct;
        int       prio_pct;
        for (int k = 0; k < n_words; k++)
        begin
            if (k % 25 == 0)
            begin
                fill_pct = $urandom_range(15, 90);
                case ($urandom_range(0, 2))
                    0:       prio_pct = 0;
                    1:       prio_pct = 100;
                    default: prio_pct = $urandom_range(0, 100);
                endcase
            end
            if ($urandom_range(0, 99) < fill_pct)
            begin
                w = insert_word(1'($urandom_range(0, 1)),
                                $urandom_range(0, 99) < prio_pct,
                                ($urandom_range(0, 3) == 0)
                                    ? wtq_pkg::MinuteW'($urandom_range(0, 2047))
                                    : wtq_pkg::MinuteW'($urandom_range(0, 12)));
            end
            else
            begin
                w = serve_word();
            end
            send_word(w);
        end
    endtask

    // run limit
    initial
    begin
        #2000000;
        $display("DONE: errors detected");
        $finish;
    end

    initial
    begin
        logic [wtq_pkg::QuotaW-1:0] phase_quota [6];
        clk       = 1'b0;
        rst_n     = 1'b0;
        req_valid = 1'b0;
        req       = '0;
        rsp_ready = 1'b0;
        cfg_we    = 1'b0;
        cfg_data  = '0;
        send_idle = 14;
        recv_idle = 49;
        phase_quota[0] = 4'd1;
        phase_quota[1] = 4'd15;
        phase_quota[2] = 4'd0;
        phase_quota[3] = 4'd7;
        phase_quota[4] = 4'd2;
        phase_quota[5] = wtq_pkg::QuotaW'($urandom_range(1, 14));

        repeat (2) @(negedge clk);
        rst_n = 1'b1;

        // directed: empty serve, fill with extreme and repeated minutes,
        // one insert too many, then serves under the reset quota
        send_word(serve_word());
        send_word(insert_word(1'b0, 1'b1, 11'd100));
        send_word(insert_word(1'b1, 1'b0, 11'd100));
        send_word(insert_word(1'b0, 1'b0, 11'd0));
        send_word(insert_word(1'b1, 1'b1, 11'd2047));
        send_word(insert_word(1'b0, 1'b1, 11'd1439));
        send_word(insert_word(1'b1, 1'b0, 11'd50));
        send_word(insert_word(1'b0, 1'b0, 11'd100));
        send_word(insert_word(1'b1, 1'b1, 11'd100));
        send_word(insert_word(1'b0, 1'b1, 11'd0));
        send_word(insert_word(1'b1, 1'b0, 11'd1439));
        send_word(insert_word(1'b0, 1'b0, 11'd2047));
        send_word(insert_word(1'b1, 1'b1, 11'd7));
        send_word(insert_word(1'b0, 1'b1, 11'd7));
        send_word(insert_word(1'b1, 1'b0, 11'd7));
        send_word(insert_word(1'b0, 1'b0, 11'd1000));
        send_word(insert_word(1'b1, 1'b1, 11'd1000));
        send_word(insert_word(1'b1, 1'b1, 11'd5));
        repeat (7) send_word(serve_word());

        // random phases: two per idling mix, a new quota each time
        for (int p = 0; p < 6; p++)
        begin
            case (p / 2)
                0:
                begin
                    send_idle = 14;
                    recv_idle = 49;
                end
                1:
                begin
                    send_idle = 49;
                    recv_idle = 14;
                end
                default:
                begin
                    send_idle = 0;
                    recv_idle = 0;
                end
            endcase
            load_quota(phase_quota[p]);
            random_traffic(PhaseWords);
        end

        // drain and give the verdict
        @(negedge clk);
        req_valid <= 1'b0;
        while (outstanding != 0)
            @(negedge clk);
        repeat (10) @(posedge clk);
        if (mismatches == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

// ===== filelist.f =====
hdl/wtq_pkg.sv
hdl/wtq_cell.sv
hdl/weighted_two_class_time_queue_unit.sv
hdl/wtq_checker.sv
test/wtq_checker.sv
test/tb.sv
